// ===== sv/sha_pkg.sv =====
`default_nettype none
package sha_pkg;
   localparam int QueueDepth = 4;

   typedef logic [31:0] word_type;

   // One queued request: a byte (or none) and the end-of-message flag.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       message_end;
   } item_type;

   localparam logic [7:0] PAD_MARK = 8'h80;

   function automatic word_type round_k(input logic [5:0] r);
      word_type k [64] = '{
         32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
         32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
         32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
         32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
         32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
         32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
         32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
         32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
         32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
         32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
         32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
         32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
         32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
         32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
         32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
         32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return k[r];
   endfunction

   function automatic word_type init_hash(input logic [2:0] i);
      word_type h [8] = '{
         32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
         32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      return h[i];
   endfunction

   function automatic word_type rotr(input word_type x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction
endpackage
`default_nettype wire

// ===== sv/sha_front.sv =====
`default_nettype none
// Accepts requests, drops those that carry neither byte nor end, and queues the rest.
module sha_front
   import sha_pkg::*;
#(
   parameter int DEPTH = QueueDepth
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire item_type in_item,
   output logic          q_valid,
   input  wire logic     q_ready,
   output item_type      q_item
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   item_type       mem_ff [DEPTH];
   logic [AW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]    cnt_ff, cnt_in;
   logic           push, pop, useful;

   assign useful   = in_item.byte_valid | in_item.message_end;
   assign in_ready = (cnt_ff != (AW+1)'(DEPTH));
   assign push     = in_valid & in_ready & useful;
   assign q_valid  = (cnt_ff != '0);
   assign pop      = q_valid & q_ready;
   assign q_item   = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (pop)  rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= in_item;
   end

   a_cnt_max: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (AW+1)'(DEPTH)) else $error("queue overfilled");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == '0 |-> !pop) else $error("pop from empty queue");
   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 1'b1) else $error("count slip");
endmodule
`default_nettype wire

// ===== sv/sha_core.sv =====
`default_nettype none
// Block buffer, padding sequencer, one-round-per-cycle compression and digest output.
module sha_core
   import sha_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     q_valid,
   output logic          q_ready,
   input  wire item_type q_item,
   output logic          out_valid,
   input  wire logic     out_ready,
   output word_type      out_word,
   output logic [2:0]    out_index,
   output logic          out_last
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PAD  = 3'd1;
   localparam logic [2:0] S_LEN  = 3'd2;
   localparam logic [2:0] S_RUN  = 3'd3;
   localparam logic [2:0] S_ADD  = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   logic [2:0]  st_ff, st_in;
   logic [63:0] bits_ff, bits_in;
   logic        fin_ff, fin_in;     // compression belongs to the end of a message
   logic        more_ff, more_in;   // another padded block follows this one
   logic [5:0]  rnd_ff, rnd_in;
   logic [2:0]  oi_ff, oi_in;
   logic [5:0]  pp_ff, pp_in;      // byte position of the padding pass
   word_type    h_ff [8];
   word_type    v_ff [8];
   word_type    w_ff [16];          // block buffer, then message schedule window
   logic [5:0]  pos;
   word_type    wt, wn, s0, s1, t1, t2;
   logic        take, wr_en, run, load, add;
   logic [5:0]  wr_pos;
   logic [7:0]  wr_byte;
   logic        clr_ff, clr_in;     // zero bytes past the mark

   assign pos = bits_ff[8:3];
   assign q_ready = (st_ff == S_IDLE);
   assign take = q_valid & q_ready;

   assign wt = w_ff[0];
   assign s0 = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
   assign s1 = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
   assign wn = s1 + w_ff[9] + s0 + w_ff[0];
   assign t1 = v_ff[7] + (rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25))
             + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) + round_k(rnd_ff) + wt;
   assign t2 = (rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22))
             + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));

   // After a data block ends a message, padding still has to start.
   function automatic logic st_pad_pending();
      return !clr_ff;
   endfunction

   always_comb begin
      st_in = st_ff; bits_in = bits_ff; fin_in = fin_ff; more_in = more_ff;
      rnd_in = rnd_ff; oi_in = oi_ff; clr_in = clr_ff; pp_in = pp_ff;
      wr_en = 1'b0; wr_pos = pos; wr_byte = q_item.data_byte;
      load = 1'b0; run = 1'b0; add = 1'b0;
      case (st_ff)
         S_IDLE: if (take) begin
            fin_in = q_item.message_end;
            if (q_item.byte_valid) begin
               wr_en = 1'b1;
               bits_in = bits_ff + 64'd8;
               if (pos == 6'd63) begin
                  load = 1'b1; st_in = S_RUN; rnd_in = '0;
               end else if (q_item.message_end) st_in = S_PAD;
            end else st_in = S_PAD;
            pp_in = bits_in[8:3];
         end
         S_PAD: begin
            // Mark, then zeros up to byte 55 (or to the block end when the length does not fit), one byte per cycle.
            wr_en = 1'b1;
            wr_pos = pp_ff;
            wr_byte = clr_ff ? 8'h00 : PAD_MARK;
            clr_in = 1'b1;
            pp_in = pp_ff + 1'b1;
            if (pp_ff == 6'd63) begin
               load = 1'b1; st_in = S_RUN; rnd_in = '0;
               more_in = 1'b1;
            end else if (pp_ff == 6'd55) st_in = S_LEN;
         end
         S_LEN: begin
            load = 1'b1; st_in = S_RUN; rnd_in = '0; more_in = 1'b0;
         end
         S_RUN: begin
            run = 1'b1; rnd_in = rnd_ff + 1'b1;
            if (rnd_ff == 6'd63) st_in = S_ADD;
         end
         S_ADD: begin
            add = 1'b1;
            if (!fin_ff) st_in = S_IDLE;
            else if (more_ff || st_pad_pending()) st_in = S_PAD;
            else begin st_in = S_OUT; oi_in = '0; end
         end
         S_OUT: if (out_ready) begin
            oi_in = oi_ff + 1'b1;
            if (oi_ff == 3'd7) begin
               st_in = S_IDLE; bits_in = '0; clr_in = 1'b0; more_in = 1'b0;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   assign out_valid = (st_ff == S_OUT);
   assign out_word  = h_ff[oi_ff];
   assign out_index = oi_ff;
   assign out_last  = (oi_ff == 3'd7);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; bits_ff <= '0; fin_ff <= 1'b0; more_ff <= 1'b0;
         rnd_ff <= '0; oi_ff <= '0; clr_ff <= 1'b0; pp_ff <= '0;
         for (int i = 0; i < 8; i++) h_ff[i] <= init_hash(3'(i));
      end else begin
         st_ff <= st_in; bits_ff <= bits_in; fin_ff <= fin_in; more_ff <= more_in;
         rnd_ff <= rnd_in; oi_ff <= oi_in; clr_ff <= clr_in; pp_ff <= pp_in;
         if (add) for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
         if (st_ff == S_OUT && out_ready && oi_ff == 3'd7)
            for (int i = 0; i < 8; i++) h_ff[i] <= init_hash(3'(i));
      end
      if (wr_en)
         case (wr_pos[1:0])
            2'd0: w_ff[wr_pos[5:2]][31:24] <= wr_byte;
            2'd1: w_ff[wr_pos[5:2]][23:16] <= wr_byte;
            2'd2: w_ff[wr_pos[5:2]][15:8]  <= wr_byte;
            default: w_ff[wr_pos[5:2]][7:0] <= wr_byte;
         endcase
      if (st_ff == S_LEN) begin
         // The message bit count fills the last eight bytes, high word first.
         w_ff[14] <= bits_ff[63:32];
         w_ff[15] <= bits_ff[31:0];
      end
      if (load) for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
      if (run) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= wn;
         v_ff[7] <= v_ff[6]; v_ff[6] <= v_ff[5]; v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2]; v_ff[2] <= v_ff[1]; v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
   end

   a_out_only: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> !q_ready) else $error("digest overlaps intake");
   a_rnd: assert property (@(posedge clock) disable iff (reset)
      st_ff == S_RUN && rnd_ff == 6'd63 |=> st_ff == S_ADD) else $error("round slip");
   a_last: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_ready && out_last |=> st_ff == S_IDLE) else $error("exit slip");
endmodule
`default_nettype wire

// ===== sv/sha256_stream_hasher_unit.sv =====
`default_nettype none
// Channel   Ports        Contents (low bit first)
// request   req_t*       tdata: data_byte[7:0]; tuser: byte_valid, message_end
// response  rsp_t*       tdata: digest_word[31:0]; tuser: word_index[2:0]; tlast
//
// The core takes a byte whenever it is idle; every 64th byte starts a 64-round
// compression; intake waits through the rounds and the chaining-word addition.
// Message end pads one byte per cycle and runs one or two more blocks, then
// presents eight digest words, one per cycle while rsp_tready is high.
// Reset is synchronous; the request queue lets the sender run ahead of a stall.
module sha256_stream_hasher_unit
   import sha_pkg::*;
#(
   parameter int QUEUE_DEPTH = QueueDepth
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // data_byte
   input  wire logic [1:0]  req_tuser,   // byte_valid, message_end
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // digest_word
   output logic [2:0]       rsp_tuser,   // word_index
   output logic             rsp_tlast
);
   item_type in_item, q_item;
   logic     q_valid, q_ready;

   assign in_item.data_byte   = req_tdata;
   assign in_item.byte_valid  = req_tuser[0];
   assign in_item.message_end = req_tuser[1];

   sha_front #(.DEPTH(QUEUE_DEPTH)) u_front (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready), .in_item,
      .q_valid, .q_ready, .q_item);

   sha_core u_core (
      .clock, .reset, .q_valid, .q_ready, .q_item,
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_word(rsp_tdata),
      .out_index(rsp_tuser), .out_last(rsp_tlast));
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none
module tb;
   import sha_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;    // data_byte
   logic [1:0]  req_tuser = '0;    // byte_valid, message_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // digest_word
   logic [2:0]  rsp_tuser;         // word_index
   logic        rsp_tlast;

   sha256_stream_hasher_unit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   always #5 clock = ~clock;

   typedef struct {
      word_type   digest_word;
      logic [2:0] word_index;
      logic       last_word;
   } digest_out_type;

   // Requests waiting to be driven, and digest words still to arrive.
   item_type       pending_requests[$];
   digest_out_type expected_words[$];

   // Predictor state: chaining words, the current block and the bit count.
   word_type    chain[8];
   logic [7:0]  block_bytes[64];
   logic [63:0] message_bits;

   int  error_count = 0;
   int  cycle_count = 0;
   bit  stimulus_done = 1'b0;

   function automatic word_type ror(word_type x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // One 64-round compression of the current block into the chaining words.
   task automatic compress();
      word_type w[64];
      word_type v[8];
      word_type t1, t2;
      for (int r = 0; r < 16; r++)
         w[r] = {block_bytes[4*r], block_bytes[4*r+1], block_bytes[4*r+2],
                 block_bytes[4*r+3]};
      for (int r = 16; r < 64; r++)
         w[r] = (ror(w[r-2], 17) ^ ror(w[r-2], 19) ^ (w[r-2] >> 10)) + w[r-7]
              + (ror(w[r-15], 7) ^ ror(w[r-15], 18) ^ (w[r-15] >> 3)) + w[r-16];
      for (int i = 0; i < 8; i++) v[i] = chain[i];
      for (int r = 0; r < 64; r++) begin
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(r[5:0]) + w[r];
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += v[i];
   endtask

   task automatic restart_message();
      for (int i = 0; i < 8; i++) chain[i] = init_hash(i[2:0]);
      message_bits = '0;
   endtask

   // Advance the hash state by one accepted request and queue any digest words.
   task automatic hash_request(item_type req);
      int pos;
      if (req.byte_valid) begin
         pos = int'(message_bits[8:3]);
         block_bytes[pos] = req.data_byte;
         message_bits += 64'd8;
         if (pos == 63) compress();
      end
      if (req.message_end) begin
         pos = int'(message_bits[8:3]);
         block_bytes[pos] = PAD_MARK;
         pos++;
         if (pos > 56) begin
            for (int i = pos; i < 64; i++) block_bytes[i] = 8'h00;
            compress();
            for (int i = 0; i < 56; i++) block_bytes[i] = 8'h00;
         end else begin
            for (int i = pos; i < 56; i++) block_bytes[i] = 8'h00;
         end
         for (int i = 0; i < 8; i++) block_bytes[56+i] = message_bits[63-8*i -: 8];
         compress();
         for (int i = 0; i < 8; i++)
            expected_words.push_back('{chain[i], i[2:0], i == 7});
         restart_message();
      end
   endtask

   function automatic item_type make_request(logic [7:0] b, logic v, logic e);
      item_type it;
      it.data_byte = b;
      it.byte_valid = v;
      it.message_end = e;
      return it;
   endfunction

   // A message of n random bytes, the final byte either riding on the end
   // request or followed by a separate end request.
   task automatic add_message(int n);
      for (int i = 0; i < n; i++) begin
         if (i == n - 1 && $urandom_range(1, 0))
            pending_requests.push_back(make_request(8'($urandom), 1'b1, 1'b1));
         else
            pending_requests.push_back(make_request(8'($urandom), 1'b1, 1'b0));
         if ($urandom_range(9, 0) == 0)
            pending_requests.push_back(make_request(8'($urandom), 1'b0, 1'b0));
      end
      if (n == 0 || pending_requests[$].message_end == 1'b0)
         pending_requests.push_back(make_request(8'($urandom), 1'b0, 1'b1));
   endtask

   // Driver: bursts of random length separated by random gaps.
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) hash_request(pending_requests.pop_front());
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_tvalid <= 1'b0;
         end else if (pending_requests.size() > 0 && !(req_tvalid && req_tready
                      && pending_requests.size() == 0)) begin
            if (req_tvalid && !req_tready) begin
               // Hold the current request until it is taken.
            end else if (burst_left == 0) begin
               burst_left <= $urandom_range(12, 1);
               gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
               req_tvalid <= 1'b0;
            end else begin
               burst_left <= burst_left - 1;
               req_tvalid <= 1'b1;
               req_tdata <= pending_requests[0].data_byte;
               req_tuser <= {pending_requests[0].message_end,
                             pending_requests[0].byte_valid};
            end
         end else if (!(req_tvalid && !req_tready)) begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver stall pattern: phases of always-ready, random and long stalls.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      case ((cycle_count / 500) % 3)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(1, 0));
         default: rsp_tready <= ($urandom_range(7, 0) == 0);
      endcase
   end

   // Monitor: compare each digest word against the oldest expected one.
   digest_out_type want;
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected digest word %h index %0d last %b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
            error_count++;
         end else begin
            want = expected_words.pop_front();
            if (rsp_tdata !== want.digest_word || rsp_tuser !== want.word_index
                || rsp_tlast !== want.last_word) begin
               $display("%0t: digest mismatch expected %h/%0d/%b actual %h/%0d/%b",
                        $time, want.digest_word, want.word_index, want.last_word,
                        rsp_tdata, rsp_tuser, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   initial begin
      int idle;
      restart_message();
      // Directed: empty message, "abc", a byte on the end request, idle
      // requests, extreme byte values, and a one-byte message.
      add_message(0);
      pending_requests.push_back(make_request(8'h61, 1'b1, 1'b0));
      pending_requests.push_back(make_request(8'h00, 1'b0, 1'b0));
      pending_requests.push_back(make_request(8'h62, 1'b1, 1'b0));
      pending_requests.push_back(make_request(8'h63, 1'b1, 1'b1));
      pending_requests.push_back(make_request(8'hff, 1'b1, 1'b0));
      pending_requests.push_back(make_request(8'h00, 1'b1, 1'b0));
      pending_requests.push_back(make_request(8'hff, 1'b0, 1'b1));
      add_message(1);
      // Random: a few short messages, then one that needs the extra padding
      // block and one that fills a whole block.
      for (int i = 0; i < 4; i++) add_message($urandom_range(6, 0));
      add_message(56);
      add_message(64);
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      wait (pending_requests.size() == 0);
      @(posedge clock);
      wait (req_tvalid == 1'b0 || req_tready == 1'b1);
      wait (expected_words.size() == 0);
      idle = 0;
      while (idle < 300) begin
         @(posedge clock);
         idle++;
      end
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Generous limit well above the slowest correct run.
   always @(posedge clock) begin
      if (cycle_count > 400000) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end
endmodule
`default_nettype wire

// ===== files.f =====
sv/sha_pkg.sv
sv/sha_front.sv
sv/sha_core.sv
sv/sha256_stream_hasher_unit.sv
tb/tb.sv
